[hw/rtl/utf8_stream_decoder_assert.svh]
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Property checked on every clock edge outside of reset
`define U8SD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/u8sd_pkg.sv]
// Package for the UTF-8 stream decoder: result type, byte classes and constants.
// No dependencies; used by u8sd_decode and utf8_stream_decoder.
package u8sd_pkg;

    localparam int unsigned ValueWidth   = 31;
    localparam int unsigned MinimumWidth = 27;
    localparam int unsigned PendWidth    = 3;

    // Smallest legal value for each sequence length (2 to 6 bytes)
    localparam logic [MinimumWidth-1:0] Min2 = 27'h0000080;
    localparam logic [MinimumWidth-1:0] Min3 = 27'h0000800;
    localparam logic [MinimumWidth-1:0] Min4 = 27'h0010000;
    localparam logic [MinimumWidth-1:0] Min5 = 27'h0200000;
    localparam logic [MinimumWidth-1:0] Min6 = 27'h4000000;

    localparam logic [5:0] ContMask = 6'h3F;

    // One decoded result
    typedef struct packed {
        logic [ValueWidth-1:0] code_value;
        logic                  malformed;
        logic                  overlong;
        logic                  last_of_run;
    } result_t;

    // Coarse class of an incoming byte
    typedef enum logic [1:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD,
        CLS_INVALID
    } byte_class_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        priority if (!b[7])               c = CLS_ASCII;
        else if (b[7:6] == 2'b10)         c = CLS_CONT;
        else if (b[7:1] == 7'b1111111)    c = CLS_INVALID;
        else                              c = CLS_LEAD;
        return c;
    endfunction

endpackage

[hw/rtl/u8sd_decode.sv]
// Per-byte decode step of the UTF-8 stream decoder: sequence state and result build.
// Depends on u8sd_pkg and utf8_stream_decoder_assert.svh.
`include "utf8_stream_decoder_assert.svh"

module u8sd_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output u8sd_pkg::result_t res0,
    output u8sd_pkg::result_t res1,
    output logic [1:0]        res_count
);

    logic [u8sd_pkg::PendWidth-1:0]    pend_reg,  pend_next;
    logic [u8sd_pkg::ValueWidth-1:0]   bits_reg,  bits_next;
    logic [u8sd_pkg::MinimumWidth-1:0] min_reg,   min_next;

    u8sd_pkg::byte_class_t               cls;
    logic                                flush;
    logic [u8sd_pkg::ValueWidth-1:0]     flush_val;
    logic                                flush_over;
    logic [u8sd_pkg::ValueWidth-1:0]     cont_val;
    logic [u8sd_pkg::ValueWidth-1:0]     raw_val;
    logic [u8sd_pkg::PendWidth-1:0]      lead_len;
    logic [u8sd_pkg::ValueWidth-1:0]     lead_bits;
    logic [u8sd_pkg::MinimumWidth-1:0]   lead_min;
    logic                                own;
    u8sd_pkg::result_t                   own_res;
    u8sd_pkg::result_t                   flush_res;

    assign cls     = u8sd_pkg::classify(in_byte);
    assign raw_val = {{(u8sd_pkg::ValueWidth-8){1'b0}}, in_byte};
    assign cont_val = {bits_reg[u8sd_pkg::ValueWidth-7:0], in_byte[5:0] & u8sd_pkg::ContMask};

    // Cut-short partial: pad missing continuation bytes with zero bits
    always_comb
    begin
        unique case (pend_reg)
            3'd1:    flush_val = {bits_reg[24:0], 6'd0};
            3'd2:    flush_val = {bits_reg[18:0], 12'd0};
            3'd3:    flush_val = {bits_reg[12:0], 18'd0};
            3'd4:    flush_val = {bits_reg[6:0], 24'd0};
            3'd5:    flush_val = {bits_reg[0], 30'd0};
            default: flush_val = bits_reg;
        endcase
    end

    assign flush_over = flush_val < {{(u8sd_pkg::ValueWidth-u8sd_pkg::MinimumWidth){1'b0}}, min_reg};
    assign flush      = (pend_reg != '0) && (cls != u8sd_pkg::CLS_CONT);

    // Lead byte: sequence length, payload bits and minimum value
    always_comb
    begin
        priority if (in_byte[7:5] == 3'b110)
        begin
            lead_len  = 3'd1;
            lead_bits = {26'd0, in_byte[4:0]};
            lead_min  = u8sd_pkg::Min2;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            lead_len  = 3'd2;
            lead_bits = {27'd0, in_byte[3:0]};
            lead_min  = u8sd_pkg::Min3;
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            lead_len  = 3'd3;
            lead_bits = {28'd0, in_byte[2:0]};
            lead_min  = u8sd_pkg::Min4;
        end
        else if (in_byte[7:2] == 6'b111110)
        begin
            lead_len  = 3'd4;
            lead_bits = {29'd0, in_byte[1:0]};
            lead_min  = u8sd_pkg::Min5;
        end
        else
        begin
            lead_len  = 3'd5;
            lead_bits = {30'd0, in_byte[0]};
            lead_min  = u8sd_pkg::Min6;
        end
    end

    // Byte's own result and next sequence state
    always_comb
    begin
        own       = 1'b0;
        own_res   = '{code_value: raw_val, malformed: 1'b0, overlong: 1'b0, last_of_run: 1'b1};
        pend_next = '0;
        bits_next = raw_val;
        min_next  = '0;
        unique case (cls)
            u8sd_pkg::CLS_ASCII:
            begin
                own = 1'b1;
            end
            u8sd_pkg::CLS_CONT:
            begin
                if (pend_reg == '0)
                begin
                    own               = 1'b1;
                    own_res.malformed = 1'b1;
                end
                else
                begin
                    pend_next = pend_reg - 3'd1;
                    bits_next = cont_val;
                    if (pend_reg == 3'd1)
                    begin
                        own                = 1'b1;
                        own_res.code_value = cont_val;
                        own_res.overlong   = cont_val <
                            {{(u8sd_pkg::ValueWidth-u8sd_pkg::MinimumWidth){1'b0}}, min_reg};
                    end
                    else
                    begin
                        min_next = min_reg;
                    end
                end
            end
            u8sd_pkg::CLS_LEAD:
            begin
                pend_next = lead_len;
                bits_next = lead_bits;
                min_next  = lead_min;
            end
            default:
            begin
                own               = 1'b1;
                own_res.malformed = 1'b1;
            end
        endcase
    end

    assign flush_res = '{code_value: flush_val, malformed: 1'b1, overlong: flush_over,
                         last_of_run: !own};

    // Order results: cut-short partial first, then the byte's own
    always_comb
    begin
        res_count = {1'b0, flush} + {1'b0, own};
        res0      = flush ? flush_res : own_res;
        res1      = own_res;
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            bits_reg <= '0;
            min_reg  <= '0;
        end
        else if (step)
        begin
            pend_reg <= pend_next;
            bits_reg <= bits_next;
            min_reg  <= min_next;
        end
    end

    `U8SD_ASSERT_ALWAYS(a_pend_range, !rst_n || (pend_reg <= 3'd5), "pending count out of range")
    `U8SD_ASSERT(a_idle_min_zero, (pend_reg == '0) |-> (min_reg == '0), "minimum kept while idle")
    `U8SD_ASSERT(a_pair_order, (res_count == 2'd2) |-> (res0.malformed && !res0.last_of_run), "bad pair order")

endmodule

[hw/rtl/utf8_stream_decoder.sv]
// A byte is held in the input register while it is decoded; its results go into the
// result queue, which drives the output. Throughput: one byte per cycle for bytes with
// one result while the receiver takes each result. A byte with two results waits for an
// empty result queue (room ignores this cycle's output handshake).
// Reset (rst_n, async, active low) empties the input stage and queue and clears the
// sequence state; no clearing pass.
// Depends on u8sd_pkg, u8sd_decode and utf8_stream_decoder_assert.svh.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [30:0] code_value, [31] zero
    output logic [1:0]  m_axis_tuser,    // [0] malformed, [1] overlong
    output logic        m_axis_tlast     // last_of_run
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic [1:0]        cnt_reg, cnt_next;
    u8sd_pkg::result_t q0_reg, q0_next;
    u8sd_pkg::result_t q1_reg, q1_next;

    u8sd_pkg::result_t res0, res1;
    logic [1:0]        res_count;
    logic [1:0]        room;
    logic              dec_go;
    logic              pop;
    logic [1:0]        left;
    u8sd_pkg::result_t base0;

    u8sd_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (dec_go),
        .in_byte   (in_byte_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    // Decode fires when the queue has room for every result of the byte
    assign room          = 2'd2 - cnt_reg;
    assign dec_go        = in_valid_reg && (res_count <= room);
    assign s_axis_tready = !in_valid_reg || dec_go;
    assign in_valid_next = (s_axis_tvalid && s_axis_tready) ? 1'b1
                         : (dec_go ? 1'b0 : in_valid_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Result queue: pop the head, shift, then append new results
    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        base0 = pop ? q1_reg : q0_reg;
        left  = pop ? (cnt_reg - 2'd1) : cnt_reg;
        q0_next  = base0;
        q1_next  = q1_reg;
        cnt_next = left;
        if (dec_go)
        begin
            unique case (left)
                2'd0:
                begin
                    q0_next = res0;
                    q1_next = res1;
                end
                2'd1:
                begin
                    q1_next = res0;
                end
                default:
                begin
                end
            endcase
            cnt_next = left + res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    // Output port
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {1'b0, q0_reg.code_value};
    assign m_axis_tuser  = {q0_reg.overlong, q0_reg.malformed};
    assign m_axis_tlast  = q0_reg.last_of_run;

    `U8SD_ASSERT_ALWAYS(a_cnt_range, !rst_n || (cnt_reg != 2'd3), "result queue overfilled")
    `U8SD_ASSERT(a_go_fills, (dec_go && (res_count != 2'd0)) |=> m_axis_tvalid, "result lost")
    `U8SD_ASSERT(a_pair_queued, (m_axis_tvalid && !m_axis_tlast) |-> (cnt_reg == 2'd2), "pair split")

endmodule

[verif/tb_utf8_stream_decoder.sv]
// Testbench for utf8_stream_decoder: byte requests in, decoded code values out, checked
// against a decoder kept here in step with every accepted byte.
// Depends on u8sd_pkg and the utf8_stream_decoder RTL.
module tb_utf8_stream_decoder;

    localparam int unsigned IdleLimit = 500;
    localparam int unsigned TailCycles = 8;

    typedef enum
    {
        RX_ALWAYS,
        RX_RANDOM,
        RX_STALLS
    } rx_pattern_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Decoder state mirrored from the block
    logic [2:0]  dec_left;
    logic [30:0] dec_bits;
    logic [26:0] dec_floor;

    u8sd_pkg::result_t decoded_q [$];

    int unsigned check_errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned malformed_seen = 0;
    int unsigned overlong_seen = 0;
    int unsigned idle_cycles = 0;

    // Sender and receiver pacing
    bit          tx_gaps = 1'b0;
    int unsigned tx_burst_left = 0;
    rx_pattern_t rx_mode = RX_ALWAYS;
    int unsigned rx_hold = 0;

    utf8_stream_decoder i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] in_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [30:0] code_value, [31] zero
        .m_axis_tuser  (m_axis_tuser),    // [0] malformed, [1] overlong
        .m_axis_tlast  (m_axis_tlast)     // last_of_run
    );

    always #10 clk = ~clk;

    // Decode one byte and queue the results it causes, in order
    function automatic void decode_byte(input logic [7:0] b);
        u8sd_pkg::result_t run [$];
        u8sd_pkg::result_t r;
        logic [30:0]       v;
        // A lead, an ASCII or an FE/FF byte cuts a pending sequence short
        if ((!b[7] || b[7:6] == 2'b11) && dec_left != 3'd0)
        begin
            v = dec_bits << (6 * dec_left);
            r.code_value = v;
            r.malformed = 1'b1;
            r.overlong = (v < dec_floor);
            run.push_back(r);
            dec_left = 3'd0;
            dec_floor = '0;
        end
        unique casez (b)
            8'b0???????:
            begin
                dec_bits = 31'(b);
                dec_floor = '0;
                r.code_value = 31'(b);
                r.malformed = 1'b0;
                r.overlong = 1'b0;
                run.push_back(r);
            end
            8'b10??????:
            begin
                if (dec_left == 3'd0)
                begin
                    // stray continuation carries its raw value
                    dec_bits = 31'(b);
                    dec_floor = '0;
                    r.code_value = 31'(b);
                    r.malformed = 1'b1;
                    r.overlong = 1'b0;
                    run.push_back(r);
                end
                else
                begin
                    dec_left = dec_left - 3'd1;
                    dec_bits = {dec_bits[24:0], b[5:0]};
                    if (dec_left == 3'd0)
                    begin
                        r.code_value = dec_bits;
                        r.malformed = 1'b0;
                        r.overlong = (dec_bits < dec_floor);
                        run.push_back(r);
                        dec_floor = '0;
                    end
                end
            end
            8'b110?????:
            begin
                dec_left = 3'd1;
                dec_bits = 31'(b[4:0]);
                dec_floor = u8sd_pkg::Min2;
            end
            8'b1110????:
            begin
                dec_left = 3'd2;
                dec_bits = 31'(b[3:0]);
                dec_floor = u8sd_pkg::Min3;
            end
            8'b11110???:
            begin
                dec_left = 3'd3;
                dec_bits = 31'(b[2:0]);
                dec_floor = u8sd_pkg::Min4;
            end
            8'b111110??:
            begin
                dec_left = 3'd4;
                dec_bits = 31'(b[1:0]);
                dec_floor = u8sd_pkg::Min5;
            end
            8'b1111110?:
            begin
                dec_left = 3'd5;
                dec_bits = 31'(b[0]);
                dec_floor = u8sd_pkg::Min6;
            end
            default:
            begin
                // 0xFE and 0xFF are never valid
                dec_bits = 31'(b);
                dec_floor = '0;
                r.code_value = 31'(b);
                r.malformed = 1'b1;
                r.overlong = 1'b0;
                run.push_back(r);
            end
        endcase
        // only the final result of this byte closes its run
        foreach (run[i])
        begin
            run[i].last_of_run = (i == run.size() - 1);
            decoded_q.push_back(run[i]);
        end
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            check_errors++;
        end
    endfunction

    // Track input requests, then check each output request against the queue
    always @(posedge clk)
    begin : check_results
        u8sd_pkg::result_t want;
        if (!rst_n)
        begin
            dec_left = 3'd0;
            dec_bits = '0;
            dec_floor = '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual tdata %h tuser %b tlast %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    check_errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    results_seen++;
                    malformed_seen += want.malformed;
                    overlong_seen += want.overlong;
                    compare_field("code_value", 32'(want.code_value), 32'(m_axis_tdata[30:0]));
                    compare_field("tdata pad", 32'd0, 32'(m_axis_tdata[31]));
                    compare_field("malformed", 32'(want.malformed), 32'(m_axis_tuser[0]));
                    compare_field("overlong", 32'(want.overlong), 32'(m_axis_tuser[1]));
                    compare_field("last_of_run", 32'(want.last_of_run), 32'(m_axis_tlast));
                end
            end
        end
    end

    // Receiver ready pattern
    always @(posedge clk)
    begin
        unique case (rx_mode)
            RX_ALWAYS:
                m_axis_tready <= 1'b1;
            RX_RANDOM:
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_hold != 0)
                begin
                    m_axis_tready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_hold <= $urandom_range(1, 8);
                end
            end
        endcase
    end

    // Watchdog: end the run when no request moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, decoded_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one byte, with a random gap between bursts when gaps are on
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && tx_burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            tx_burst_left = $urandom_range(1, 12);
        end
        if (tx_burst_left != 0)
            tx_burst_left--;
        s_axis_tdata <= b;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Hold off the sender until every queued result has come out
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (decoded_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Send the first keep bytes of a random sequence of len bytes
    task automatic send_sequence(input int unsigned len, input int unsigned keep);
        logic [31:0]  v;
        logic [7:0]   lead_prefix;
        int unsigned  nbits;
        if (len == 1)
        begin
            send_byte({1'b0, 7'($urandom)});
            return;
        end
        nbits = 5 * len + 1;
        v = $urandom & ((32'h1 << nbits) - 32'h1);
        // small values give overlong encodings
        if ($urandom_range(0, 3) == 0)
            v = v >> $urandom_range(0, nbits);
        case (len)
            2:       lead_prefix = 8'hC0;
            3:       lead_prefix = 8'hE0;
            4:       lead_prefix = 8'hF0;
            5:       lead_prefix = 8'hF8;
            default: lead_prefix = 8'hFC;
        endcase
        send_byte(lead_prefix | 8'(v >> (6 * (len - 1))));
        for (int j = 1; j < keep; j++)
            send_byte(8'h80 | 8'((v >> (6 * (len - 1 - j))) & 32'h3F));
    endtask

    // Field extremes and each bad case, back to back
    task automatic test_directed_cases();
        logic [7:0] seq [$];
        seq = '{8'h00, 8'h7F,                               // ASCII extremes
                8'hC0, 8'h80,                               // overlong 2-byte
                8'hE2, 8'h82, 8'hAC,                        // good 3-byte
                8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,   // largest 6-byte value
                8'h80, 8'hBF,                               // stray continuations
                8'hFE, 8'hFF,                               // never-valid bytes
                8'hE2, 8'h82, 8'hC3, 8'hA9,                 // cut short by a lead
                8'hF8, 8'h41,                               // cut short by ASCII
                8'hFC, 8'hFE};                              // cut short by 0xFE
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        foreach (seq[i])
            send_byte(seq[i]);
        wait_results_done();
    endtask

    // Mostly complete sequences of random length and content
    task automatic test_wellformed_stream(input int unsigned count, input bit gaps,
                                          input rx_pattern_t pattern);
        int unsigned stop_at;
        int unsigned len;
        tx_gaps = gaps;
        rx_mode = pattern;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            len = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom));
            else
                send_sequence(len, len);
            if ($urandom_range(0, 99) == 0)
                wait_results_done();
        end
        wait_results_done();
    endtask

    // Raw noise, truncated sequences and some good ones mixed
    task automatic test_broken_stream(input int unsigned count);
        int unsigned stop_at;
        int unsigned len;
        tx_gaps = 1'b1;
        rx_mode = RX_RANDOM;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            len = $urandom_range(2, 6);
            case ($urandom_range(0, 9))
                0, 1, 2: send_byte(8'($urandom));
                3, 4, 5: send_sequence(len, $urandom_range(1, len - 1));
                default: send_sequence(len, len);
            endcase
            if ($urandom_range(0, 99) == 0)
                wait_results_done();
        end
        wait_results_done();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_wellformed_stream(300, 1'b0, RX_ALWAYS);
        test_wellformed_stream(400, 1'b1, RX_RANDOM);
        test_wellformed_stream(400, 1'b1, RX_STALLS);
        test_broken_stream(480);

        wait_results_done();
        repeat (TailCycles) @(posedge clk);
        if (decoded_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, decoded_q.size());
            check_errors++;
        end

        $display("Run sent %0d bytes and checked %0d results (%0d malformed, %0d overlong).",
                 bytes_sent, results_seen, malformed_seen, overlong_seen);
        $display("Streams: directed cases, well-formed and broken random input, gaps and stalls.");
        if (check_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_decode.sv
hw/rtl/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
